FILE: rtl/wee_pkg.sv
`timescale 1ns / 1ps
package wee_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int POS_W = 48;
  localparam int COL_W = 32;
  localparam int ROT_W = 64;
  localparam int QC_W = 16;
  localparam int FRAC_Q = 14;

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_QUAD = 2'd2,
    KIND_BOX  = 2'd3
  } prim_kind_t;

  typedef enum logic [1:0] {
    FS_IDLE  = 2'd0,
    FS_ISSUE = 2'd1,
    FS_DRAIN = 2'd2
  } front_state_t;

  typedef struct packed {
    prim_kind_t             kind;
    logic [7:0][POS_W-1:0]  pts;
    logic [3:0][COL_W-1:0]  cols;
  } prim_entry_t;

  localparam logic [2:0] BOX_EDGE [24] = '{
    3'd0, 3'd1, 3'd1, 3'd3, 3'd3, 3'd2, 3'd2, 3'd0,
    3'd4, 3'd5, 3'd5, 3'd7, 3'd7, 3'd6, 3'd6, 3'd4,
    3'd0, 3'd4, 3'd1, 3'd5, 3'd3, 3'd7, 3'd2, 3'd6};
  localparam logic [2:0] QUAD_EDGE [8] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd0};
  localparam logic [2:0] TRI_EDGE [6] = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd0};

  function automatic logic [2:0] edge_vtx(prim_kind_t kind, logic [4:0] j);
    logic [2:0] r;
    r = 3'd0;
    case (kind)
      KIND_LINE: r = {2'b00, j[0]};
      KIND_TRI:  r = (j < 5'd6) ? TRI_EDGE[j[2:0]] : 3'd0;
      KIND_QUAD: r = QUAD_EDGE[j[2:0]];
      KIND_BOX:  r = (j < 5'd24) ? BOX_EDGE[j] : 3'd0;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] last_idx(prim_kind_t kind);
    logic [4:0] r;
    r = 5'd1;
    case (kind)
      KIND_LINE: r = 5'd1;
      KIND_TRI:  r = 5'd5;
      KIND_QUAD: r = 5'd7;
      KIND_BOX:  r = 5'd23;
      default:   r = 5'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/wee_corner.sv
`timescale 1ns / 1ps
module wee_corner #(
  parameter int COORD_BITS = wee_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      issue_valid,
  input  logic [2:0]                issue_idx,
  input  logic [wee_pkg::POS_W-1:0] centre,
  input  logic [wee_pkg::POS_W-1:0] half,
  input  logic [wee_pkg::ROT_W-1:0] rot,
  output logic                      corner_valid,
  output logic [2:0]                corner_idx,
  output logic [wee_pkg::POS_W-1:0] corner_pos
);
  import wee_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int EW  = (3 * C > POS_W) ? 3 * C : POS_W;
  localparam int VW  = C + 1;
  localparam int P1W = C + 17;
  localparam int D1W = C + 18;
  localparam int UVW = C + 4;
  localparam int P2W = C + 20;
  localparam int D2W = C + 21;
  localparam int TW  = C + 8;
  localparam int SW  = C + 12;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic [EW-1:0] c_ext, h_ext;
  logic signed [C-1:0] c_l [3];
  logic signed [C-1:0] h_l [3];
  logic signed [QC_W-1:0] q [3];
  logic signed [QC_W-1:0] w;
  logic signed [VW-1:0] v0 [3];

  logic [3:0] vld_r;
  logic [2:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [VW-1:0] v1_r [3];
  logic signed [VW-1:0] v2_r [3];
  logic signed [VW-1:0] v3_r [3];
  logic signed [P1W-1:0] m1_r [6];
  logic signed [UVW-1:0] uv_r [3];
  logic signed [P2W-1:0] m2_r [6];
  logic signed [P2W-1:0] mw_r [3];
  logic signed [D1W-1:0] d1 [3];
  logic signed [D2W-1:0] d2 [3];
  logic signed [SW-1:0] sum [3];
  logic signed [C-1:0] ps [3];
  logic [EW-1:0] pk;
  logic [POS_W-1:0] pos_r;

  assign c_ext = EW'(centre);
  assign h_ext = EW'(half);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_l[k] = c_ext[k*C +: C];
      h_l[k] = h_ext[k*C +: C];
      q[k]   = rot[k*QC_W +: QC_W];
      v0[k]  = issue_idx[k] ? VW'(h_l[k]) : -VW'(h_l[k]);
    end
    w = rot[3*QC_W +: QC_W];
  end

  // cross terms: r0 = a1*b2 - a2*b1, r1 = a2*b0 - a0*b2, r2 = a0*b1 - a1*b0
  always_ff @(posedge clk) begin
    m1_r[0] <= q[1] * v0[2];
    m1_r[1] <= q[2] * v0[1];
    m1_r[2] <= q[2] * v0[0];
    m1_r[3] <= q[0] * v0[2];
    m1_r[4] <= q[0] * v0[1];
    m1_r[5] <= q[1] * v0[0];
    v1_r    <= v0;
    idx1_r  <= issue_idx;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1[k] = D1W'(m1_r[2*k]) - D1W'(m1_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      uv_r[k] <= UVW'(d1[k] >>> FRAC_Q);
    end
    v2_r   <= v1_r;
    idx2_r <= idx1_r;
  end

  always_ff @(posedge clk) begin
    m2_r[0] <= q[1] * uv_r[2];
    m2_r[1] <= q[2] * uv_r[1];
    m2_r[2] <= q[2] * uv_r[0];
    m2_r[3] <= q[0] * uv_r[2];
    m2_r[4] <= q[0] * uv_r[1];
    m2_r[5] <= q[1] * uv_r[0];
    for (int k = 0; k < 3; k++) begin
      mw_r[k] <= uv_r[k] * w;
    end
    v3_r   <= v2_r;
    idx3_r <= idx2_r;
  end

  always_comb begin
    pk = '0;
    for (int k = 0; k < 3; k++) begin
      d2[k] = D2W'(m2_r[2*k]) - D2W'(m2_r[2*k+1]);
      sum[k] = SW'(v3_r[k]) + SW'(TW'(mw_r[k] >>> (FRAC_Q - 1)))
             + (SW'(TW'(d2[k] >>> FRAC_Q)) <<< 1) + SW'(c_l[k]);
      if (sum[k] > SAT_HI) begin
        ps[k] = C'(SAT_HI);
      end else if (sum[k] < SAT_LO) begin
        ps[k] = C'(SAT_LO);
      end else begin
        ps[k] = C'(sum[k]);
      end
      pk[k*C +: C] = ps[k];
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pk[POS_W-1:0];
    idx4_r <= idx3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], issue_valid};
    end
  end

  assign corner_valid = vld_r[3];
  assign corner_idx   = idx4_r;
  assign corner_pos   = pos_r;

endmodule

FILE: rtl/wee_front.sv
`timescale 1ns / 1ps
module wee_front #(
  parameter int COORD_BITS = wee_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      pass_sel,
  input  logic [1:0]                req_type,
  input  logic [wee_pkg::POS_W-1:0] vert_a,
  input  logic [wee_pkg::POS_W-1:0] vert_b,
  input  logic [wee_pkg::POS_W-1:0] vert_c,
  input  logic [wee_pkg::POS_W-1:0] vert_d,
  input  logic [wee_pkg::COL_W-1:0] color_a,
  input  logic [wee_pkg::COL_W-1:0] color_b,
  input  logic [wee_pkg::COL_W-1:0] color_c,
  input  logic [wee_pkg::COL_W-1:0] color_d,
  input  logic [wee_pkg::ROT_W-1:0] box_rotation,
  input  logic                      skip_depth_test,
  input  logic                      fill_solid,
  input  logic                      fifo_full,
  output logic                      push,
  output wee_pkg::prim_entry_t      push_entry
);
  import wee_pkg::*;

  front_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] ctr_r, half_r;
  logic [ROT_W-1:0] rot_r;
  logic [COL_W-1:0] bcol_r;
  logic [7:0][POS_W-1:0] cbuf_r;
  logic accept, keep, is_box, issue_valid, corner_valid, box_done;
  logic [2:0] corner_idx;
  logic [POS_W-1:0] corner_pos;
  prim_kind_t kind;

  assign kind   = prim_kind_t'(req_type);
  assign accept = start && !busy;
  assign keep   = (skip_depth_test == pass_sel) && !(kind == KIND_TRI && fill_solid);
  assign is_box = kind == KIND_BOX;
  assign box_done = (state_r == FS_DRAIN) && corner_valid && (corner_idx == 3'd7);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      FS_IDLE: begin
        cnt_nxt = 3'd0;
        if (accept && keep && is_box) state_nxt = FS_ISSUE;
      end
      FS_ISSUE: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) state_nxt = FS_DRAIN;
      end
      FS_DRAIN: begin
        if (box_done) state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != FS_IDLE) || fifo_full;
    issue_valid = state_r == FS_ISSUE;
    push        = (accept && keep && !is_box) || box_done;
    push_entry  = '0;
    if (state_r == FS_IDLE) begin
      push_entry.kind = kind;
      push_entry.pts[0] = vert_a;
      push_entry.pts[1] = vert_b;
      push_entry.pts[2] = vert_c;
      push_entry.pts[3] = vert_d;
      push_entry.cols[0] = color_a;
      push_entry.cols[1] = color_b;
      push_entry.cols[2] = color_c;
      push_entry.cols[3] = color_d;
    end else begin
      push_entry.kind    = KIND_BOX;
      push_entry.pts     = cbuf_r;
      push_entry.pts[7]  = corner_pos;
      push_entry.cols[0] = bcol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // hold the box operands while its corners go through the pipeline
  always_ff @(posedge clk) begin
    if (accept && is_box) begin
      ctr_r  <= vert_a;
      half_r <= vert_b;
      rot_r  <= box_rotation;
      bcol_r <= color_a;
    end
    if (corner_valid) cbuf_r[corner_idx] <= corner_pos;
  end

  wee_corner #(
    .COORD_BITS(COORD_BITS)
  ) u_corner (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_idx   (cnt_r),
    .centre      (ctr_r),
    .half        (half_r),
    .rot         (rot_r),
    .corner_valid(corner_valid),
    .corner_idx  (corner_idx),
    .corner_pos  (corner_pos)
  );

endmodule

FILE: rtl/wee_fifo.sv
`timescale 1ns / 1ps
module wee_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wee_pkg::prim_entry_t push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output wee_pkg::prim_entry_t head
);
  import wee_pkg::*;

  prim_entry_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/wee_emit.sv
`timescale 1ns / 1ps
module wee_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  wee_pkg::prim_entry_t      head,
  output logic                      pop,
  output logic                      out_valid,
  output logic [wee_pkg::POS_W-1:0] out_position,
  output logic [wee_pkg::COL_W-1:0] out_color,
  output logic                      out_last
);
  import wee_pkg::*;

  logic [4:0] j_r, j_nxt;
  logic [2:0] vi;
  logic last;
  logic out_valid_r, out_last_r;
  logic [POS_W-1:0] out_position_r;
  logic [COL_W-1:0] out_color_r;

  assign vi   = edge_vtx(head.kind, j_r);
  assign last = j_r == last_idx(head.kind);
  assign pop  = head_valid && last;
  assign j_nxt = !head_valid ? j_r : (last ? 5'd0 : j_r + 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r         <= 5'd0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      j_r         <= j_nxt;
      out_valid_r <= head_valid;
      out_last_r  <= head_valid && last;
    end
  end

  always_ff @(posedge clk) begin
    out_position_r <= head.pts[vi];
    out_color_r    <= (head.kind == KIND_BOX) ? head.cols[0] : head.cols[vi[1:0]];
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_color    = out_color_r;
  assign out_last     = out_last_r;

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r) else $error("last marker without strobe");
  a_mid_head: assert property (@(posedge clk) disable iff (!rst_n)
    j_r != 5'd0 |-> head_valid) else $error("primitive head lost mid-emission");
  a_emit_follow: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |=> out_valid_r) else $error("queued vertex not emitted");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> j_r <= last_idx(head.kind)) else $error("vertex index overrun");

endmodule

FILE: rtl/wireframe_edge_expander_unit.sv
`timescale 1ns / 1ps
// Wireframe edge expander: one debug primitive per transaction in, line-list
// vertices out.
// Input: present fields with start; the transaction is taken at a clock edge
// where start is high and busy is low. Lines, triangles and quads are taken
// back to back, one per cycle, while the two-entry queue has room. A box
// holds busy while its 8 corners pass the shared rotation pipeline (one
// corner issued per cycle, four stages deep).
// Output: each vertex appears for one cycle with out_valid; out_last marks
// the final vertex of a primitive. The emitter gives one vertex per cycle:
// 2 for a line, 6 for a triangle, 8 for a quad, 24 for a box. A new box can
// be taken while the last is still emitted. A line, triangle or quad is
// queued at acceptance, a box once its last corner leaves the pipeline.
// The receiver cannot stall; out_valid is a strobe.
// Config: cfg_depth_pass_select is written when cfg_valid is high
// (cfg_ready is always high); write it only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue, drops work in flight and
// selects the depth-tested pass.
module wireframe_edge_expander_unit #(
  parameter int COORD_BITS = wee_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic [wee_pkg::POS_W-1:0] in_vert_a,
  input  logic [wee_pkg::POS_W-1:0] in_vert_b,
  input  logic [wee_pkg::POS_W-1:0] in_vert_c,
  input  logic [wee_pkg::POS_W-1:0] in_vert_d,
  input  logic [wee_pkg::COL_W-1:0] in_color_a,
  input  logic [wee_pkg::COL_W-1:0] in_color_b,
  input  logic [wee_pkg::COL_W-1:0] in_color_c,
  input  logic [wee_pkg::COL_W-1:0] in_color_d,
  input  logic [wee_pkg::ROT_W-1:0] in_box_rotation,
  input  logic                      in_skip_depth_test,
  input  logic                      in_fill_solid,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_depth_pass_select,
  output logic                      out_valid,
  output logic [wee_pkg::POS_W-1:0] out_position,
  output logic [wee_pkg::COL_W-1:0] out_color,
  output logic                      out_last
);
  import wee_pkg::*;

  logic pass_r;
  logic fifo_full, push, pop, head_valid;
  prim_entry_t push_entry, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pass_r <= cfg_depth_pass_select;
    end
  end

  wee_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .pass_sel       (pass_r),
    .req_type       (in_req_type),
    .vert_a         (in_vert_a),
    .vert_b         (in_vert_b),
    .vert_c         (in_vert_c),
    .vert_d         (in_vert_d),
    .color_a        (in_color_a),
    .color_b        (in_color_b),
    .color_c        (in_color_c),
    .color_d        (in_color_d),
    .box_rotation   (in_box_rotation),
    .skip_depth_test(in_skip_depth_test),
    .fill_solid     (in_fill_solid),
    .fifo_full      (fifo_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  wee_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (fifo_full),
    .head_valid(head_valid),
    .head      (head)
  );

  wee_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_position(out_position),
    .out_color   (out_color),
    .out_last    (out_last)
  );

endmodule
